/* sv/assert_macros.svh */
// Assertion macros used by the checker module of the frustum cull block.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Whenever a holds, b holds in the same cycle.
`define ASSERT_SAME(label, clk, rst_n, a, b, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error(msg);

// Whenever a holds, b holds a fixed number of cycles later.
`define ASSERT_LATER(label, clk, rst_n, a, n, b, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> ##n (b)) \
        else $error(msg);

`endif

/* sv/fac_pkg.sv */
// Package for the frustum cull block: plane record type and fixed constants.
// No dependencies.
`default_nettype none

package fac_pkg;

    localparam int NUM_PLANES      = 6;
    localparam int NORM_W          = 16;
    localparam int FRAC_BITS       = 14;
    localparam int COORD_WIDTH_DEF = 16;
    localparam int CFG_DATA_W      = 64;
    // Six 64-bit registers at 8-byte spacing.
    localparam int ADDR_W          = 6;
    localparam int REG_SHIFT       = 3;
    localparam int IDX_W           = ADDR_W - REG_SHIFT;
    // Latency from an accepted box to its result strobe, in cycles.
    localparam int LATENCY         = 4;

    typedef struct packed {
        logic signed [NORM_W-1:0] nx;
        logic signed [NORM_W-1:0] ny;
        logic signed [NORM_W-1:0] nz;
        logic signed [NORM_W-1:0] offset;
    } plane_t;

endpackage

`default_nettype wire

/* sv/frustum_aabb_cull.sv */
// Frustum culling of axis-aligned boxes against six fixed-point clip planes.
// Depends on fac_pkg.
//
//  channel   handshake            payload
//  box in    start, busy          min_x min_y min_z max_x max_y max_z
//  result    done (one cycle)     visible
//  config    APB psel/penable     paddr, pwdata, prdata (plane registers)
//
// One box is taken every cycle; busy is never raised. The result strobe done
// follows the accepting edge through the input register, the normal-times-
// corner products, the per-plane sums and the output register. The depth is set
// by the eighteen multipliers and the four-term adders behind them.
// Reset clears the stage valid bits and the plane registers to zero.
`default_nettype none

module frustum_aabb_cull
    import fac_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)
(
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire                           start,
    output logic                          busy,
    input  wire signed [COORD_WIDTH-1:0]  min_x,
    input  wire signed [COORD_WIDTH-1:0]  min_y,
    input  wire signed [COORD_WIDTH-1:0]  min_z,
    input  wire signed [COORD_WIDTH-1:0]  max_x,
    input  wire signed [COORD_WIDTH-1:0]  max_y,
    input  wire signed [COORD_WIDTH-1:0]  max_z,
    output logic                          done,
    output logic                          visible,
    input  wire                           psel,
    input  wire                           penable,
    input  wire                           pwrite,
    input  wire        [ADDR_W-1:0]       paddr,
    input  wire        [CFG_DATA_W-1:0]   pwdata,
    output logic       [CFG_DATA_W-1:0]   prdata,
    output logic                          pready
);

    localparam int PROD_W = NORM_W + COORD_WIDTH;
    localparam int OFFS_W = NORM_W + FRAC_BITS;
    localparam int SUM_W  = ((PROD_W > OFFS_W) ? PROD_W : OFFS_W) + 2;

    // Configuration registers
    plane_t              planes_reg [NUM_PLANES];
    logic [IDX_W-1:0]    cfg_idx;
    logic                cfg_wr;

    assign pready  = 1'b1;
    assign busy    = 1'b0;
    assign cfg_idx = paddr[ADDR_W-1:REG_SHIFT];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < NUM_PLANES; p++)
            begin
                planes_reg[p] <= '0;
            end
        end
        else if (cfg_wr && (int'(cfg_idx) < NUM_PLANES))
        begin
            planes_reg[cfg_idx] <= plane_t'(pwdata);
        end
    end

    always_comb
    begin
        prdata = '0;
        if (int'(cfg_idx) < NUM_PLANES)
        begin
            prdata = CFG_DATA_W'(planes_reg[cfg_idx]);
        end
    end

    // Stage 1: register the box and flag an inverted one.
    logic                          s1_valid_reg;
    logic signed [COORD_WIDTH-1:0] s1_lo_reg [3];
    logic signed [COORD_WIDTH-1:0] s1_hi_reg [3];
    logic                          s1_inv_reg;
    logic                          s1_inv_next;

    assign s1_inv_next = (min_x > max_x) || (min_y > max_y) || (min_z > max_z);

    // Stage 2: one product per plane and axis, on the corner furthest along the normal.
    logic                     s2_valid_reg;
    logic                     s2_inv_reg;
    logic signed [PROD_W-1:0] s2_prod_reg  [NUM_PLANES][3];
    logic signed [PROD_W-1:0] s2_prod_next [NUM_PLANES][3];

    always_comb
    begin
        logic signed [NORM_W-1:0]      nrm;
        logic signed [COORD_WIDTH-1:0] crd;
        for (int p = 0; p < NUM_PLANES; p++)
        begin
            for (int a = 0; a < 3; a++)
            begin
                case (a)
                    0:       nrm = planes_reg[p].nx;
                    1:       nrm = planes_reg[p].ny;
                    default: nrm = planes_reg[p].nz;
                endcase
                crd = nrm[NORM_W-1] ? s1_lo_reg[a] : s1_hi_reg[a];
                s2_prod_next[p][a] = PROD_W'(nrm) * PROD_W'(crd);
            end
        end
    end

    // Stage 3: signed distance per plane; only its sign is kept.
    logic                  s3_valid_reg;
    logic                  s3_inv_reg;
    logic [NUM_PLANES-1:0] s3_neg_reg;
    logic [NUM_PLANES-1:0] s3_neg_next;

    always_comb
    begin
        logic signed [SUM_W-1:0] dist_sum;
        for (int p = 0; p < NUM_PLANES; p++)
        begin
            dist_sum = SUM_W'(s2_prod_reg[p][0]) + SUM_W'(s2_prod_reg[p][1])
                     + SUM_W'(s2_prod_reg[p][2])
                     + (SUM_W'(planes_reg[p].offset) <<< FRAC_BITS);
            s3_neg_next[p] = dist_sum[SUM_W-1];
        end
    end

    // Stage 4: result register.
    logic done_reg;
    logic visible_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= start;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            done_reg     <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_lo_reg[0] <= min_x;
        s1_lo_reg[1] <= min_y;
        s1_lo_reg[2] <= min_z;
        s1_hi_reg[0] <= max_x;
        s1_hi_reg[1] <= max_y;
        s1_hi_reg[2] <= max_z;
        s1_inv_reg   <= s1_inv_next;
        s2_inv_reg   <= s1_inv_reg;
        s2_prod_reg  <= s2_prod_next;
        s3_inv_reg   <= s2_inv_reg;
        s3_neg_reg   <= s3_neg_next;
        visible_reg  <= !s3_inv_reg && (s3_neg_reg == '0);
    end

    assign done    = done_reg;
    assign visible = visible_reg;

endmodule

`default_nettype wire

/* sv/fac_checker.sv */
// Port-level assertions for the frustum cull block, bound to its top level.
// Depends on fac_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module fac_checker
    import fac_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)
(
    input wire                          clk,
    input wire                          rst_n,
    input wire                          start,
    input wire                          busy,
    input wire signed [COORD_WIDTH-1:0] min_x,
    input wire signed [COORD_WIDTH-1:0] min_y,
    input wire signed [COORD_WIDTH-1:0] min_z,
    input wire signed [COORD_WIDTH-1:0] max_x,
    input wire signed [COORD_WIDTH-1:0] max_y,
    input wire signed [COORD_WIDTH-1:0] max_z,
    input wire                          done,
    input wire                          visible
);

    logic accepted;
    logic inverted;

    assign accepted = start && !busy;
    assign inverted = (min_x > max_x) || (min_y > max_y) || (min_z > max_z);

    // Every accepted box gets exactly one result, a fixed latency later.
    `ASSERT_LATER(a_result_follows, clk, rst_n, accepted, 4, done, "accepted box lost its result")
    `ASSERT_LATER(a_no_spurious, clk, rst_n, !accepted, 4, !done, "result strobe without a box")
    // An inverted box is never reported visible.
    `ASSERT_LATER(a_inverted_culled, clk, rst_n, accepted && inverted, 4, !visible,
                  "inverted box reported visible")
    // The pipeline takes a box every cycle.
    `ASSERT_SAME(a_never_busy, clk, rst_n, 1'b1, !busy, "busy raised")

endmodule

bind frustum_aabb_cull fac_checker #(.COORD_WIDTH(COORD_WIDTH)) u_fac_checker (.*);

`default_nettype wire

/* tb/frustum_aabb_cull_test.sv */
// Self-checking testbench for frustum_aabb_cull: boxes against six clip planes,
// with predicted visibility per box and APB writes and readback of the planes.
// Depends on fac_pkg and the frustum_aabb_cull RTL.
`default_nettype none

module frustum_aabb_cull_test;
    import fac_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW          = COORD_WIDTH_DEF;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_BOXES = 110;

    typedef struct packed {
        logic signed [CW-1:0] min_x;
        logic signed [CW-1:0] min_y;
        logic signed [CW-1:0] min_z;
        logic signed [CW-1:0] max_x;
        logic signed [CW-1:0] max_y;
        logic signed [CW-1:0] max_z;
    } box_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    logic signed [CW-1:0]  min_x = '0;
    logic signed [CW-1:0]  min_y = '0;
    logic signed [CW-1:0]  min_z = '0;
    logic signed [CW-1:0]  max_x = '0;
    logic signed [CW-1:0]  max_y = '0;
    logic signed [CW-1:0]  max_z = '0;
    logic                  done;
    logic                  visible;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [ADDR_W-1:0]     paddr = '0;
    logic [CFG_DATA_W-1:0] pwdata = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    logic [CFG_DATA_W-1:0] plane_regs [NUM_PLANES];
    box_t                  pending_boxes [$];
    logic                  expected_visible [$];
    logic                  box_taken = 1'b0;
    int                    errors = 0;
    int                    cycles = 0;
    int                    burst_left = 0;
    int                    gap_left = 0;

    frustum_aabb_cull #(.COORD_WIDTH(CW)) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .min_x   (min_x),
        .min_y   (min_y),
        .min_z   (min_z),
        .max_x   (max_x),
        .max_y   (max_y),
        .max_z   (max_z),
        .done    (done),
        .visible (visible),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #4 clk = ~clk;

    // A box is culled when the corner furthest along some plane normal still
    // lies on the negative side of that plane, or when it is inverted.
    function automatic logic box_in_frustum(box_t b);
        longint lo [3];
        longint hi [3];
        longint n [3];
        longint dist_acc;
        plane_t pl;
        logic   vis;
        lo[0] = b.min_x;
        lo[1] = b.min_y;
        lo[2] = b.min_z;
        hi[0] = b.max_x;
        hi[1] = b.max_y;
        hi[2] = b.max_z;
        vis = 1'b1;
        for (int a = 0; a < 3; a++)
        begin
            if (lo[a] > hi[a])
                vis = 1'b0;
        end
        for (int p = 0; p < NUM_PLANES; p++)
        begin
            pl = plane_t'(plane_regs[p]);
            n[0] = pl.nx;
            n[1] = pl.ny;
            n[2] = pl.nz;
            dist_acc = longint'(pl.offset) * (longint'(1) << FRAC_BITS);
            for (int a = 0; a < 3; a++)
                dist_acc += n[a] * ((n[a] >= 0) ? hi[a] : lo[a]);
            if (dist_acc < 0)
                vis = 1'b0;
        end
        return vis;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pack_plane(int nx, int ny, int nz, int d);
        return {16'(nx), 16'(ny), 16'(nz), 16'(d)};
    endfunction

    function automatic logic [CFG_DATA_W-1:0] oblique_plane(int lo_d, int hi_d);
        int nx;
        int ny;
        int nz;
        nx = int'($urandom_range(0, 32768)) - 16384;
        ny = int'($urandom_range(0, 32768)) - 16384;
        nz = int'($urandom_range(0, 32768)) - 16384;
        return pack_plane(nx, ny, nz, int'($urandom_range(0, hi_d - lo_d)) + lo_d);
    endfunction

    function automatic void queue_box(int lx, int ly, int lz, int hx, int hy, int hz);
        box_t b;
        b = {CW'(lx), CW'(ly), CW'(lz), CW'(hx), CW'(hy), CW'(hz)};
        pending_boxes.push_back(b);
    endfunction

    // Mostly well-formed boxes around the origin, with points, inverted axes
    // and raw random fields mixed in.
    function automatic box_t rand_box(int spread);
        box_t b;
        int   lo [3];
        int   hi [3];
        int   kind;
        int   t;
        int   a;
        kind = $urandom_range(0, 9);
        for (a = 0; a < 3; a++)
        begin
            lo[a] = int'($urandom_range(0, 2 * spread)) - spread;
            case ($urandom_range(0, 3))
                0: t = 0;
                1: t = $urandom_range(0, 16);
                default: t = $urandom_range(0, spread);
            endcase
            if (kind == 6)
                t = 0;
            hi[a] = lo[a] + t;
            if (hi[a] > 32767)
                hi[a] = 32767;
        end
        if (kind == 7)
        begin
            a = $urandom_range(0, 2);
            t = $urandom_range(1, 500);
            if (hi[a] > 32767 - t)
                hi[a] = 32767 - t;
            lo[a] = hi[a] + t;
        end
        b = {CW'(lo[0]), CW'(lo[1]), CW'(lo[2]), CW'(hi[0]), CW'(hi[1]), CW'(hi[2])};
        if (kind >= 8)
            b = box_t'({$urandom, $urandom, $urandom});
        return b;
    endfunction

    task automatic plane_write(input int idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = ADDR_W'(idx << REG_SHIFT);
        pwdata = val;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        if (idx < NUM_PLANES)
            plane_regs[idx] = val;
    endtask

    task automatic check_plane_reg(input int idx);
        logic [CFG_DATA_W-1:0] got;
        @(negedge clk);
        psel = 1'b1;
        pwrite = 1'b0;
        penable = 1'b0;
        paddr = ADDR_W'(idx << REG_SHIFT);
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        got = prdata;
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        if (got !== plane_regs[idx])
        begin
            $error("plane register %0d: expected %h, actual %h", idx, plane_regs[idx], got);
            errors++;
        end
    endtask

    // Waits until every queued box is taken and every result is back, then
    // lets the pipeline run dry before the planes are touched.
    task automatic drain_boxes();
        @(negedge clk);
        while (pending_boxes.size() != 0 || start || expected_visible.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 2)
            @(negedge clk);
    endtask

    // Sender: bursts of random length separated by random gaps.
    always @(negedge clk)
    begin
        if (!start || box_taken)
        begin
            if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                start <= 1'b0;
            end
            else if (pending_boxes.size() != 0)
            begin
                {min_x, min_y, min_z, max_x, max_y, max_z} <= pending_boxes.pop_front();
                start <= 1'b1;
                if (burst_left > 0)
                    burst_left <= burst_left - 1;
                else
                begin
                    burst_left <= $urandom_range(1, 40);
                    case ($urandom_range(0, 3))
                        0: gap_left <= 0;
                        1: gap_left <= 1;
                        2: gap_left <= $urandom_range(2, 5);
                        default: gap_left <= $urandom_range(6, 20);
                    endcase
                end
            end
            else
                start <= 1'b0;
        end
    end

    // Record each accepted beat and check each result strobe.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
        else
        begin
            box_taken = rst_n && start && !busy;
            if (box_taken)
                expected_visible.push_back(box_in_frustum({min_x, min_y, min_z,
                                                           max_x, max_y, max_z}));
            if (rst_n && done)
            begin
                if (expected_visible.size() == 0)
                begin
                    $error("visible: expected nothing, actual %0b", visible);
                    errors++;
                end
                else if (visible !== expected_visible[0])
                begin
                    $error("visible: expected %0b, actual %0b", expected_visible[0], visible);
                    errors++;
                    void'(expected_visible.pop_front());
                end
                else
                    void'(expected_visible.pop_front());
            end
        end
    end

    initial
    begin
        logic [CFG_DATA_W-1:0] vals [NUM_PLANES];
        int                    spread;
        for (int i = 0; i < NUM_PLANES; i++)
            plane_regs[i] = '0;
        repeat (6)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        for (int i = 0; i < NUM_PLANES; i++)
            check_plane_reg(i);

        // All planes zero: every well-formed box is visible.
        queue_box(-32768, -32768, -32768, 32767, 32767, 32767);
        queue_box(32767, 32767, 32767, 32767, 32767, 32767);
        queue_box(-32768, -32768, -32768, -32768, -32768, -32768);
        queue_box(0, 0, 0, 0, 0, 0);
        queue_box(-1, -1, -1, 0, 0, 0);
        queue_box(1, 0, 0, 0, 0, 0);
        queue_box(0, 1, 0, 0, 0, 0);
        queue_box(0, 0, 1, 0, 0, 0);
        queue_box(32767, -32768, -32768, -32768, 32767, 32767);
        queue_box(-5, -5, 32767, 5, 5, -32768);
        drain_boxes();

        // Single-axis planes, probed exactly on and just past the boundary.
        plane_write(0, pack_plane(16384, 0, 0, 100));
        plane_write(1, pack_plane(-16384, 0, 0, 200));
        plane_write(2, pack_plane(0, -32768, 0, 32767));
        plane_write(3, '0);
        plane_write(4, pack_plane(0, 0, 32767, -32768));
        plane_write(5, '0);
        queue_box(-32768, -100, 16385, -100, 100, 32767);
        queue_box(-32768, -100, 16385, -101, 100, 32767);
        queue_box(200, 16383, 16385, 32767, 32767, 32767);
        queue_box(201, 16383, 16385, 32767, 32767, 32767);
        queue_box(0, 16384, 16385, 0, 32767, 32767);
        queue_box(0, 0, 16384, 0, 0, 16384);
        queue_box(0, 0, 16385, 0, 0, 16385);
        queue_box(0, 0, -32768, 0, 0, 16385);
        drain_boxes();

        for (int ph = 0; ph < 8; ph++)
        begin
            spread = 3000;
            for (int i = 0; i < NUM_PLANES; i++)
            begin
                case (ph)
                    0, 7:
                    begin
                        // Axis-aligned slab: one plane per face of a box frustum.
                        vals[i] = '0;
                        case (i / 2)
                            0: vals[i][63:48] = (i % 2) ? 16'hC000 : 16'h4000;
                            1: vals[i][47:32] = (i % 2) ? 16'hC000 : 16'h4000;
                            default: vals[i][31:16] = (i % 2) ? 16'hC000 : 16'h4000;
                        endcase
                        vals[i][15:0] = 16'(int'($urandom_range(0, 3000)) - 500);
                    end
                    1: vals[i] = oblique_plane(-500, 3000);
                    2: vals[i] = '1;
                    3: vals[i] = {$urandom, $urandom};
                    4: vals[i] = 64'h8000_8000_8000_8000;
                    5: vals[i] = 64'h7FFF_7FFF_7FFF_7FFF;
                    default: vals[i] = ($urandom_range(0, 1) != 0) ? '0 :
                                       oblique_plane(-200, 2000);
                endcase
            end
            if (ph >= 2 && ph <= 5)
                spread = 32767;
            if (ph == 7)
                spread = 20000;
            for (int i = 0; i < NUM_PLANES; i++)
                plane_write(i, vals[i]);
            if (ph == 2)
            begin
                // Writes past the last plane must leave every plane alone.
                plane_write(NUM_PLANES, {$urandom, $urandom});
                plane_write(NUM_PLANES + 1, '0);
            end
            for (int i = 0; i < NUM_PLANES; i++)
                check_plane_reg(i);
            repeat (PHASE_BOXES)
                pending_boxes.push_back(rand_box(spread));
            drain_boxes();
        end

        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire
